// ===== rtl/core/saet_pkg.sv =====
// ----------------------------------------------------------------------------
// saet_pkg
// Shared types and constants of the sensor alert event tracker.
// ----------------------------------------------------------------------------
package saet_pkg;

    // Field widths of a sensor frame and of an event beat
    localparam int ID_W    = 8;
    localparam int LEVEL_W = 2;
    localparam int WORD_W  = 32;
    localparam int UNIT_W  = 8;

    // Reported levels at or above this are ignored
    localparam int LEVELS = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = '0;

    // Kind of an event beat
    typedef enum logic [0:0] {
        KIND_OPEN  = 1'b0,
        KIND_CLOSE = 1'b1
    } t_kind;

    // One row of the per-sensor table
    typedef struct packed {
        logic [LEVEL_W-1:0]       level;
        logic signed [WORD_W-1:0] open_value;
        logic [WORD_W-1:0]        open_time;
        logic [UNIT_W-1:0]        unit;
    } t_entry;

    // Up to two event beats caused by one frame, handed to the output buffer
    typedef struct packed {
        logic                     has_close;
        logic                     has_open;
        logic [ID_W-1:0]          sensor;
        logic [LEVEL_W-1:0]       close_level;
        logic [LEVEL_W-1:0]       open_level;
        logic signed [WORD_W-1:0] old_reading;
        logic [WORD_W-1:0]        old_stamp;
        logic [UNIT_W-1:0]        old_unit;
        logic signed [WORD_W-1:0] new_reading;
        logic [WORD_W-1:0]        new_stamp;
        logic [UNIT_W-1:0]        new_unit;
    } t_pend;

endpackage

// ===== rtl/core/saet_ram.sv =====
// ----------------------------------------------------------------------------
// saet_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module saet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word, read one word into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/saet_out_buf.sv =====
// ----------------------------------------------------------------------------
// saet_out_buf
// Holds the event beats of one frame and presents them in order: the
// closing beat first, then the opening beat.
// ----------------------------------------------------------------------------
module saet_out_buf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  saet_pkg::t_pend              i_pend,
    output logic                         o_load_ok,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_event_kind,
    output logic [saet_pkg::ID_W-1:0]    o_event_sensor,
    output logic [saet_pkg::LEVEL_W-1:0] o_event_level,
    output logic signed [saet_pkg::WORD_W-1:0] o_open_reading,
    output logic [saet_pkg::WORD_W-1:0]  o_open_stamp,
    output logic signed [saet_pkg::WORD_W-1:0] o_close_reading,
    output logic [saet_pkg::WORD_W-1:0]  o_close_stamp,
    output logic [saet_pkg::UNIT_W-1:0]  o_event_unit,
    output logic                         o_last
);

    import saet_pkg::*;

    t_pend r_pend;
    logic  r_has_close;
    logic  r_has_open;
    logic  beat;
    logic  show_close;
    t_kind kind;

    assign show_close = r_has_close;
    assign o_valid    = r_has_close | r_has_open;
    assign o_last     = ~(r_has_close & r_has_open);
    assign beat       = o_valid & ~i_stall;
    assign o_load_ok  = ~o_valid | (beat & o_last);

    // Hold the payload of the frame until its last beat leaves
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pend <= i_pend;
        end
    end

    // Track which beats are still owed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_close <= 1'b0;
            r_has_open  <= 1'b0;
        end else if (i_load) begin
            r_has_close <= i_pend.has_close;
            r_has_open  <= i_pend.has_open;
        end else if (beat) begin
            if (r_has_close) begin
                r_has_close <= 1'b0;
            end else begin
                r_has_open <= 1'b0;
            end
        end
    end

    // Select the fields of the beat on show
    always_comb begin
        kind = show_close ? KIND_CLOSE : KIND_OPEN;
    end

    assign o_event_kind    = kind;
    assign o_event_sensor  = r_pend.sensor;
    assign o_event_level   = show_close ? r_pend.close_level : r_pend.open_level;
    assign o_open_reading  = show_close ? r_pend.old_reading : r_pend.new_reading;
    assign o_open_stamp    = show_close ? r_pend.old_stamp : r_pend.new_stamp;
    assign o_close_reading = show_close ? r_pend.new_reading : '0;
    assign o_close_stamp   = show_close ? r_pend.new_stamp : '0;
    assign o_event_unit    = show_close ? r_pend.old_unit : r_pend.new_unit;

endmodule

// ===== rtl/core/sensor_alert_event_tracker.sv =====
// ----------------------------------------------------------------------------
// sensor_alert_event_tracker
// Follows alert episodes per sensor and reports opened and closed events.
// ----------------------------------------------------------------------------
// Each input beat is one sensor frame. A frame that moves its sensor from
// normal to an alert level gives one opening event, a frame that returns it to
// normal gives one closing event, and a frame that moves it between two alert
// levels gives a closing event followed by an opening event (last marks the
// final beat of a frame). A frame with an unchanged level, a sensor index not
// below SENSORS or a level not below the level count gives nothing. A frame
// is taken in every cycle while the output keeps up; a frame with two events
// holds up a following frame with events until its last beat leaves. The
// first event of a frame is shown once the output buffer loads it; the
// per-sensor table is a RAM with a registered read, read on the input beat
// and written as the frame leaves, with a bypass for back-to-back frames of
// the same sensor. All sensors start at normal after reset; no clearing pass.
// ----------------------------------------------------------------------------
module sensor_alert_event_tracker #(
    parameter int SENSORS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Frame channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [saet_pkg::ID_W-1:0]    i_sensor_id,
    input  logic [saet_pkg::LEVEL_W-1:0] i_alert_level,
    input  logic signed [saet_pkg::WORD_W-1:0] i_reading,
    input  logic [saet_pkg::UNIT_W-1:0]  i_unit_code,
    input  logic [saet_pkg::WORD_W-1:0]  i_now_time,
    // Event channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_event_kind,
    output logic [saet_pkg::ID_W-1:0]    o_event_sensor,
    output logic [saet_pkg::LEVEL_W-1:0] o_event_level,
    output logic signed [saet_pkg::WORD_W-1:0] o_open_reading,
    output logic [saet_pkg::WORD_W-1:0]  o_open_stamp,
    output logic signed [saet_pkg::WORD_W-1:0] o_close_reading,
    output logic [saet_pkg::WORD_W-1:0]  o_close_stamp,
    output logic [saet_pkg::UNIT_W-1:0]  o_event_unit,
    output logic                         o_last
);

    import saet_pkg::*;

    localparam int IDX_W = $clog2(SENSORS);

    // Frame register
    logic                     r_s1_valid;
    logic [ID_W-1:0]          r_s1_id;
    logic [LEVEL_W-1:0]       r_s1_level;
    logic signed [WORD_W-1:0] r_s1_reading;
    logic [UNIT_W-1:0]        r_s1_unit;
    logic [WORD_W-1:0]        r_s1_now;

    // Bypass of the write that raced the table read
    logic                     r_fwd_vld;
    logic [IDX_W-1:0]         r_fwd_id;
    t_entry                   r_fwd_entry;

    // Written flags of the table rows
    logic [SENSORS-1:0]       r_row_vld;

    logic                     in_beat;
    logic [IDX_W-1:0]         s1_idx;
    t_entry                   ram_q;
    t_entry                   stored;
    t_entry                   wr_entry;
    logic [LEVEL_W-1:0]       prev_level;
    logic                     in_range;
    logic                     has_close;
    logic                     has_open;
    logic                     s1_fire;
    logic                     s1_we;
    logic                     load_ok;
    t_pend                    pend;

    assign in_beat = i_valid & ~o_stall;
    assign s1_idx  = r_s1_id[IDX_W-1:0];

    // Per-sensor table
    saet_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SENSORS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (s1_we),
        .i_wr_addr (s1_idx),
        .i_wr_data (wr_entry),
        .i_re      (in_beat),
        .i_rd_addr (i_sensor_id[IDX_W-1:0]),
        .o_rd_data (ram_q)
    );

    // Pick the current row: bypass, table, or normal if never written
    always_comb begin
        stored = (r_fwd_vld && (r_fwd_id == s1_idx)) ? r_fwd_entry : ram_q;
        prev_level = r_row_vld[s1_idx] ? stored.level : LEVEL_NORMAL;
    end

    // Decide the events of the frame
    always_comb begin
        in_range  = (int'(r_s1_id) < SENSORS) && (int'(r_s1_level) < LEVELS);
        has_close = in_range && (prev_level != LEVEL_NORMAL) && (r_s1_level != prev_level);
        has_open  = in_range && (r_s1_level != LEVEL_NORMAL) && (r_s1_level != prev_level);
        s1_fire   = r_s1_valid && (!(has_close || has_open) || load_ok);
        s1_we     = s1_fire && (has_close || has_open);
    end

    // Build the new row; the unit stays that of the first opening
    always_comb begin
        wr_entry.level      = r_s1_level;
        wr_entry.open_value = r_s1_reading;
        wr_entry.open_time  = r_s1_now;
        wr_entry.unit       = (prev_level == LEVEL_NORMAL) ? r_s1_unit : stored.unit;
    end

    // Gather the beats for the output buffer
    always_comb begin
        pend.has_close   = has_close;
        pend.has_open    = has_open;
        pend.sensor      = r_s1_id;
        pend.close_level = prev_level;
        pend.open_level  = r_s1_level;
        pend.old_reading = stored.open_value;
        pend.old_stamp   = stored.open_time;
        pend.old_unit    = stored.unit;
        pend.new_reading = r_s1_reading;
        pend.new_stamp   = r_s1_now;
        pend.new_unit    = wr_entry.unit;
    end

    assign o_stall = r_s1_valid & ~s1_fire;

    // Advance the frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_id      <= i_sensor_id;
            r_s1_level   <= i_alert_level;
            r_s1_reading <= i_reading;
            r_s1_unit    <= i_unit_code;
            r_s1_now     <= i_now_time;
        end
    end

    // Capture the write that lands on the same edge as the next table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (in_beat) begin
            r_fwd_vld <= s1_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_fwd_id    <= s1_idx;
            r_fwd_entry <= wr_entry;
        end
    end

    // Mark rows once written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (s1_we) begin
            r_row_vld[s1_idx] <= 1'b1;
        end
    end

    // Event output buffer
    saet_out_buf u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (s1_we),
        .i_pend          (pend),
        .o_load_ok       (load_ok),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_event_sensor  (o_event_sensor),
        .o_event_level   (o_event_level),
        .o_open_reading  (o_open_reading),
        .o_open_stamp    (o_open_stamp),
        .o_close_reading (o_close_reading),
        .o_close_stamp   (o_close_stamp),
        .o_event_unit    (o_event_unit),
        .o_last          (o_last)
    );

endmodule

// ===== bench/tb_sensor_alert_event_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_alert_event_tracker
// Self-checking bench for the per-sensor alert event tracker.
// ----------------------------------------------------------------------------
// Sensor frames are driven on the frame channel. Each accepted frame is run
// through a behavioural tracker that keeps its own level, opening value,
// opening time and unit per sensor; its events, or for a typed row the one
// written out by hand, are queued. Every event beat leaving the block is
// checked field by field against the oldest queued event. A short table of
// hand-picked frames covers the field extremes, repeated levels, escalation,
// de-escalation and back-to-back frames of one sensor. A random run follows on
// a small pool of busy sensors mixed with stray ones. Both channels idle in
// short random bursts, except in the closing stretch of the run.
// ----------------------------------------------------------------------------
module tb_sensor_alert_event_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    import saet_pkg::*;

    localparam int RANDOM_FRAMES = 850;
    localparam int QUIET_FROM    = 720;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int POOL_SIZE     = 8;

    typedef struct {
        logic [ID_W-1:0]          sensor;
        logic [LEVEL_W-1:0]       level;
        logic signed [WORD_W-1:0] reading;
        logic [UNIT_W-1:0]        unit;
        logic [WORD_W-1:0]        stamp;
    } t_sensor_frame;

    typedef struct {
        t_kind                    kind;
        logic [ID_W-1:0]          sensor;
        logic [LEVEL_W-1:0]       level;
        logic signed [WORD_W-1:0] open_reading;
        logic [WORD_W-1:0]        open_stamp;
        logic signed [WORD_W-1:0] close_reading;
        logic [WORD_W-1:0]        close_stamp;
        logic [UNIT_W-1:0]        unit;
        logic                     last;
    } t_alert_event;

    typedef struct {
        t_sensor_frame frame;
        bit            typed;
        t_alert_event  want;
    } t_frame_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [ID_W-1:0]          i_sensor_id;
    logic [LEVEL_W-1:0]       i_alert_level;
    logic signed [WORD_W-1:0] i_reading;
    logic [UNIT_W-1:0]        i_unit_code;
    logic [WORD_W-1:0]        i_now_time;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_event_kind;
    logic [ID_W-1:0]          o_event_sensor;
    logic [LEVEL_W-1:0]       o_event_level;
    logic signed [WORD_W-1:0] o_open_reading;
    logic [WORD_W-1:0]        o_open_stamp;
    logic signed [WORD_W-1:0] o_close_reading;
    logic [WORD_W-1:0]        o_close_stamp;
    logic [UNIT_W-1:0]        o_event_unit;
    logic                     o_last;

    // Behavioural copy of the per-sensor table
    logic [LEVEL_W-1:0]       track_level [256];
    logic signed [WORD_W-1:0] track_value [256];
    logic [WORD_W-1:0]        track_time  [256];
    logic [UNIT_W-1:0]        track_unit  [256];

    t_alert_event  pending_events[$];
    t_frame_row    directed_rows[$];
    logic [ID_W-1:0] busy_sensors [POOL_SIZE];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            quiet;

    sensor_alert_event_tracker #(
        .SENSORS(256)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sensor_id     (i_sensor_id),
        .i_alert_level   (i_alert_level),
        .i_reading       (i_reading),
        .i_unit_code     (i_unit_code),
        .i_now_time      (i_now_time),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_event_sensor  (o_event_sensor),
        .o_event_level   (o_event_level),
        .o_open_reading  (o_open_reading),
        .o_open_stamp    (o_open_stamp),
        .o_close_reading (o_close_reading),
        .o_close_stamp   (o_close_stamp),
        .o_event_unit    (o_event_unit),
        .o_last          (o_last)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Work out the events one frame gives and advance the tracked table
    function automatic void track_frame(input t_sensor_frame f,
                                        output t_alert_event ev [2],
                                        output int count);
        logic [LEVEL_W-1:0] was;
        was   = track_level[f.sensor];
        count = 0;
        // Close the running alert on a return to normal or a level change
        if (was != LEVEL_NORMAL && f.level != was) begin
            ev[count] = '{KIND_CLOSE, f.sensor, was, track_value[f.sensor],
                          track_time[f.sensor], f.reading, f.stamp,
                          track_unit[f.sensor], f.level == LEVEL_NORMAL};
            count++;
        end
        // Open a new alert; the unit is kept across a level change
        if (f.level != LEVEL_NORMAL && f.level != was) begin
            if (was == LEVEL_NORMAL)
                track_unit[f.sensor] = f.unit;
            track_value[f.sensor] = f.reading;
            track_time[f.sensor]  = f.stamp;
            ev[count] = '{KIND_OPEN, f.sensor, f.level, f.reading, f.stamp,
                          '0, '0, track_unit[f.sensor], 1'b1};
            count++;
        end
        track_level[f.sensor] = f.level;
    endfunction

    function automatic void note_failure(input string what);
        $display("%0t: %s", $time, what);
        error_count++;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %h, actual %h",
                                   name, want, got));
    endfunction

    // Append one event to the expected queue
    function automatic void queue_event(input t_alert_event ev);
        pending_events = {pending_events, ev};
    endfunction

    // Check each event beat against the oldest queued event
    always @(posedge i_clk) begin
        t_alert_event want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0 && i_stall === 1'b0) begin
            if (pending_events.size() == 0) begin
                note_failure($sformatf({"event beat mismatch: expected none, ",
                                        "actual sensor %h level %h"},
                                       o_event_sensor, o_event_level));
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind",    32'(want.kind),     32'(o_event_kind));
                check_field("event_sensor",  32'(want.sensor),   32'(o_event_sensor));
                check_field("event_level",   32'(want.level),    32'(o_event_level));
                check_field("open_reading",  want.open_reading,  o_open_reading);
                check_field("open_stamp",    want.open_stamp,    o_open_stamp);
                check_field("close_reading", want.close_reading, o_close_reading);
                check_field("close_stamp",   want.close_stamp,   o_close_stamp);
                check_field("event_unit",    32'(want.unit),     32'(o_event_unit));
                check_field("last",          32'(want.last),     32'(o_last));
            end
        end
    end

    // Give up on a hung block
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Event channel back-pressure in short bursts
    initial begin
        int burst;
        burst   = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                burst = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic t_sensor_frame make_frame(input logic [ID_W-1:0] sensor,
                                                 input logic [LEVEL_W-1:0] level,
                                                 input logic [31:0] reading,
                                                 input logic [UNIT_W-1:0] unit,
                                                 input logic [31:0] stamp);
        t_sensor_frame f;
        f = '{sensor, level, reading, unit, stamp};
        return f;
    endfunction

    function automatic void add_row(input t_sensor_frame f);
        t_frame_row r;
        r.frame = f;
        r.typed = 1'b0;
        r.want  = '{KIND_OPEN, '0, '0, '0, '0, '0, '0, '0, 1'b0};
        directed_rows = {directed_rows, r};
    endfunction

    // Row whose single event is written out by hand
    function automatic void add_typed_row(input t_sensor_frame f, input t_kind kind,
                                          input logic [LEVEL_W-1:0] level,
                                          input logic [31:0] open_reading,
                                          input logic [31:0] open_stamp,
                                          input logic [31:0] close_reading,
                                          input logic [31:0] close_stamp,
                                          input logic [UNIT_W-1:0] unit);
        t_frame_row r;
        r.frame = f;
        r.typed = 1'b1;
        r.want  = '{kind, f.sensor, level, open_reading, open_stamp,
                    close_reading, close_stamp, unit, 1'b1};
        directed_rows = {directed_rows, r};
    endfunction

    // Random frame, mostly on the busy pool so that alerts open and close
    function automatic t_sensor_frame random_frame();
        t_sensor_frame f;
        if ($urandom_range(0, 9) < 7)
            f.sensor = busy_sensors[3'($urandom_range(0, POOL_SIZE - 1))];
        else
            f.sensor = ID_W'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
            f.level = track_level[f.sensor];
        else
            f.level = LEVEL_W'($urandom_range(0, 3));
        f.reading = $urandom;
        f.unit    = UNIT_W'($urandom_range(0, 255));
        f.stamp   = $urandom;
        return f;
    endfunction

    // Drive one frame, hold it until taken, then queue its events
    task automatic send_frame(input t_frame_row r);
        t_alert_event ev [2];
        int count;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_sensor_id   <= r.frame.sensor;
        i_alert_level <= r.frame.level;
        i_reading     <= r.frame.reading;
        i_unit_code   <= r.frame.unit;
        i_now_time    <= r.frame.stamp;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        track_frame(r.frame, ev, count);
        if (r.typed) begin
            queue_event(r.want);
        end else begin
            for (int k = 0; k < count; k++)
                queue_event(ev[k]);
        end
    endtask

    initial begin
        t_frame_row r;
        quiet         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sensor_id   = '0;
        i_alert_level = '0;
        i_reading     = '0;
        i_unit_code   = '0;
        i_now_time    = '0;
        foreach (track_level[s]) begin
            track_level[s] = LEVEL_NORMAL;
            track_value[s] = '0;
            track_time[s]  = '0;
            track_unit[s]  = '0;
        end
        foreach (busy_sensors[p])
            busy_sensors[p] = ID_W'($urandom_range(0, 255));

        // Field extremes on sensors fresh from reset
        add_typed_row(make_frame(8'd0, 2'd3, 32'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF),
                      KIND_OPEN, 2'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0, '0, 8'hFF);
        add_typed_row(make_frame(8'd255, 2'd1, 32'h8000_0000, 8'h00, 32'h0),
                      KIND_OPEN, 2'd1, 32'h8000_0000, 32'h0, '0, '0, 8'h00);
        // Same alert level again: nothing
        add_row(make_frame(8'd0, 2'd3, 32'h1234, 8'h11, 32'h99));
        // Back to normal closes with the stored opening data
        add_typed_row(make_frame(8'd0, 2'd0, 32'hFFFF_FFFF, 8'h5A, 32'h1234_5678),
                      KIND_CLOSE, 2'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'h1234_5678, 8'hFF);
        // Normal again: nothing
        add_row(make_frame(8'd0, 2'd0, 32'h0, 8'h00, 32'h0));
        // Escalate, de-escalate, repeat, then close
        add_row(make_frame(8'd255, 2'd2, 32'h1, 8'hAA, 32'd100));
        add_row(make_frame(8'd255, 2'd1, 32'hDEAD_BEEF, 8'h33, 32'd200));
        add_row(make_frame(8'd255, 2'd1, 32'h0, 8'h44, 32'd300));
        add_row(make_frame(8'd255, 2'd0, 32'h8000_0000, 8'hFF, 32'hFFFF_FFFF));
        // Alternating bit patterns
        add_typed_row(make_frame(8'd128, 2'd2, 32'h5555_5555, 8'h55, 32'hAAAA_AAAA),
                      KIND_OPEN, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA, '0, '0, 8'h55);
        add_row(make_frame(8'd128, 2'd3, 32'hAAAA_AAAA, 8'hAA, 32'h5555_5555));
        add_row(make_frame(8'd128, 2'd0, 32'h0F0F_0F0F, 8'hF0, 32'hF0F0_F0F0));
        // Back-to-back frames of one sensor
        add_row(make_frame(8'd1, 2'd1, 32'd10, 8'd7, 32'd1000));
        add_row(make_frame(8'd1, 2'd2, 32'd20, 8'd8, 32'd1001));
        add_row(make_frame(8'd1, 2'd3, 32'd30, 8'd9, 32'd1002));
        add_row(make_frame(8'd1, 2'd0, 32'd40, 8'd10, 32'd1003));
        add_row(make_frame(8'd1, 2'd2, 32'd50, 8'd11, 32'd1004));
        // Neighbouring sensors interleaved
        add_row(make_frame(8'd2, 2'd3, 32'hFFFF_0000, 8'd12, 32'd2000));
        add_row(make_frame(8'd1, 2'd0, 32'd60, 8'd13, 32'd2001));
        add_row(make_frame(8'd2, 2'd1, 32'h0000_FFFF, 8'd14, 32'd2002));
        add_row(make_frame(8'd2, 2'd0, 32'd0, 8'd15, 32'd2003));

        // Hold reset, then release it
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_frame(directed_rows[n]);

        r.typed = 1'b0;
        r.want  = directed_rows[0].want;
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            if (n == QUIET_FROM)
                quiet = 1'b1;
            r.frame = random_frame();
            send_frame(r);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain, then watch for stray beats
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/saet_pkg.sv
rtl/core/saet_ram.sv
rtl/core/saet_out_buf.sv
rtl/core/sensor_alert_event_tracker.sv
bench/tb_sensor_alert_event_tracker.sv
